// File: rtl/core/bmm_pkg.sv
// Shared types and constants of the batched matrix multiply block.
package bmm_pkg;

	localparam int MAX_DIM_DEF    = 8;
	localparam int MAX_BATCH_DEF  = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// Fraction bits of the fixed point format.
	localparam int FRAC_BITS = 16;

	// Width used for range compares, enough for any index and any size limit.
	localparam int CMP_W = 9;

	// Depth of the command queue between front and back.
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_WRITE_A,
		CMD_WRITE_B,
		CMD_READ,
		CMD_REJECT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [2:0]  row_index;
		logic [2:0]  col_index;
		logic [3:0]  batch_index;
		logic [31:0] element_value;
	} cmd_t;

	typedef struct packed {
		logic [4:0] batch_count;
		logic [3:0] b_cols;
		logic [3:0] inner_size;
		logic [3:0] a_rows;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_RESULT
	} back_state_t;

endpackage

// File: rtl/core/batched_matrix_multiply.sv
// Top level of the batched matrix multiply block.
// In the back end an A or B write or a reject is done once it reaches the queue head
// with the result slot free; a product read walks the A and B store ports one
// multiply per cycle, drains and loads the result (no walk when inner size is 0).
// Throughput: one item at a time in the back end; a 2-entry queue keeps intake open.
// Reset (arst_n low) clears control state and restores the size registers to their
// maximum values; the A and B stores keep undefined contents until written.
module batched_matrix_multiply
	import bmm_pkg::*;
#(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int MAX_BATCH  = MAX_BATCH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // row_index[2:0], col_index[5:3], batch_index[9:6],
	                               // element_value[41:10], zero pad [47:42]
	input  logic [1:0]  s_tuser,   // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // product_value
	output logic [0:0]  m_tuser    // status
);

	cfg_t cfg;
	cmd_t push_cmd, head_cmd;
	logic q_full, q_push, q_pop, head_valid, status;

	bmm_front #(
		.MAX_DIM   (MAX_DIM),
		.MAX_BATCH (MAX_BATCH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (push_cmd),
		.cfg      (cfg)
	);

	bmm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	bmm_back #(
		.MAX_DIM    (MAX_DIM),
		.MAX_BATCH  (MAX_BATCH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.q_pop         (q_pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.product_value (m_tdata),
		.status        (status)
	);

	assign m_tuser[0] = status;

endmodule

// File: rtl/core/bmm_front.sv
// Front end: configuration registers, item intake and range classification.
module bmm_front
	import bmm_pkg::*;
#(
	parameter int MAX_DIM   = MAX_DIM_DEF,
	parameter int MAX_BATCH = MAX_BATCH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // row_index, col_index, batch_index, element_value, zero pad
	input  logic [1:0]  s_tuser,   // action
	input  logic        q_full,
	output logic        q_push,
	output cmd_t        q_cmd,
	output cfg_t        cfg
);

	localparam logic [1:0] REG_A_ROWS      = 2'd0;
	localparam logic [1:0] REG_INNER_SIZE  = 2'd1;
	localparam logic [1:0] REG_B_COLS      = 2'd2;
	localparam logic [1:0] REG_BATCH_COUNT = 2'd3;

	localparam logic [1:0] ACT_WRITE_A = 2'd0;
	localparam logic [1:0] ACT_WRITE_B = 2'd1;
	localparam logic [1:0] ACT_READ    = 2'd2;

	cfg_t cfg_q;
	logic cfg_wr;

	logic [CMP_W-1:0] row_c, col_c, bat_c;
	logic [CMP_W-1:0] nr_c, nk_c, nc_c, nb_c;
	logic             bat_ok, a_ok, b_ok, rd_ok;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.a_rows      <= 4'd8;
			cfg_q.inner_size  <= 4'd8;
			cfg_q.b_cols      <= 4'd8;
			cfg_q.batch_count <= 5'd16;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_A_ROWS:      cfg_q.a_rows      <= pwdata[3:0];
				REG_INNER_SIZE:  cfg_q.inner_size  <= pwdata[3:0];
				REG_B_COLS:      cfg_q.b_cols      <= pwdata[3:0];
				REG_BATCH_COUNT: cfg_q.batch_count <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_A_ROWS:      prdata = 32'(cfg_q.a_rows);
			REG_INNER_SIZE:  prdata = 32'(cfg_q.inner_size);
			REG_B_COLS:      prdata = 32'(cfg_q.b_cols);
			REG_BATCH_COUNT: prdata = 32'(cfg_q.batch_count);
			default:         prdata = '0;
		endcase
	end

	// Sizes above the storage limits behave as the limits themselves.
	always_comb begin
		row_c  = CMP_W'(s_tdata[2:0]);
		col_c  = CMP_W'(s_tdata[5:3]);
		bat_c  = CMP_W'(s_tdata[9:6]);
		nr_c   = (CMP_W'(cfg_q.a_rows) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM)
			: CMP_W'(cfg_q.a_rows);
		nk_c   = (CMP_W'(cfg_q.inner_size) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM)
			: CMP_W'(cfg_q.inner_size);
		nc_c   = (CMP_W'(cfg_q.b_cols) > CMP_W'(MAX_DIM)) ? CMP_W'(MAX_DIM)
			: CMP_W'(cfg_q.b_cols);
		nb_c   = (CMP_W'(cfg_q.batch_count) > CMP_W'(MAX_BATCH)) ? CMP_W'(MAX_BATCH)
			: CMP_W'(cfg_q.batch_count);
		bat_ok = bat_c < nb_c;
		a_ok   = bat_ok && (row_c < nr_c) && (col_c < nk_c);
		b_ok   = bat_ok && (row_c < nk_c) && (col_c < nc_c);
		rd_ok  = bat_ok && (row_c < nr_c) && (col_c < nc_c);
	end

	always_comb begin
		q_cmd.row_index     = s_tdata[2:0];
		q_cmd.col_index     = s_tdata[5:3];
		q_cmd.batch_index   = s_tdata[9:6];
		q_cmd.element_value = s_tdata[41:10];
		case (s_tuser)
			ACT_WRITE_A: q_cmd.kind = a_ok  ? CMD_WRITE_A : CMD_REJECT;
			ACT_WRITE_B: q_cmd.kind = b_ok  ? CMD_WRITE_B : CMD_REJECT;
			ACT_READ:    q_cmd.kind = rd_ok ? CMD_READ    : CMD_REJECT;
			default:     q_cmd.kind = CMD_REJECT;
		endcase
	end

	assign s_tready = !q_full;
	assign q_push   = s_tvalid & !q_full;

endmodule

// File: rtl/core/bmm_queue.sv
// Short command queue that decouples the front end from the execution back end.
module bmm_queue
	import bmm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic head_valid,
	output cmd_t head_cmd
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             entries_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = count_q == CNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/bmm_back.sv
// Back end: A and B stores, multiply-accumulate sequencer and result register.
module bmm_back
	import bmm_pkg::*;
#(
	parameter int MAX_DIM    = MAX_DIM_DEF,
	parameter int MAX_BATCH  = MAX_BATCH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        head_valid,
	input  cmd_t        head_cmd,
	output logic        q_pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] product_value,
	output logic        status
);

	localparam int DIM_W     = $clog2(MAX_DIM);
	localparam int BAT_W     = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
	localparam int NW        = $clog2(MAX_DIM + 1);
	localparam int AW        = 2 * DIM_W + BAT_W;
	localparam int MEM_DEPTH = 2 ** AW;
	localparam int PROD_W    = 2 * DATA_WIDTH;
	localparam int ACC_W     = PROD_W + DIM_W + 1;

	localparam logic signed [ACC_W-1:0] SAT_MAX =
		{{(ACC_W - DATA_WIDTH + 1){1'b0}}, {(DATA_WIDTH - 1){1'b1}}};
	localparam logic signed [ACC_W-1:0] SAT_MIN =
		{{(ACC_W - DATA_WIDTH + 1){1'b1}}, {(DATA_WIDTH - 1){1'b0}}};

	logic [DATA_WIDTH-1:0] a_mem [MEM_DEPTH];
	logic [DATA_WIDTH-1:0] b_mem [MEM_DEPTH];

	back_state_t state_q, state_d;

	logic [DIM_W-1:0] r_q, c_q, k_q;
	logic [BAT_W-1:0] m_q;
	logic [NW-1:0]    n_q, n_cfg;
	logic             k_last;

	logic                     v_s1, last_s1, v_s2, last_s2;
	logic [DATA_WIDTH-1:0]    a_rd_s1, b_rd_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q, shifted;
	logic [DATA_WIDTH-1:0]    sat_val;

	logic                  out_valid_q, out_status_q;
	logic [DATA_WIDTH-1:0] out_data_q;

	logic          out_free;
	logic          a_we, b_we, rd_en, out_load, out_from_acc, out_reject, start_read;
	logic [AW-1:0] wr_addr, a_raddr, b_raddr;

	assign n_cfg = (CMP_W'(cfg.inner_size) > CMP_W'(MAX_DIM)) ? NW'(MAX_DIM)
		: NW'(cfg.inner_size);
	assign k_last   = (NW'(k_q) + NW'(1)) == n_q;
	assign out_free = !out_valid_q || out_ready;

	assign wr_addr = {DIM_W'(head_cmd.row_index), DIM_W'(head_cmd.col_index),
		BAT_W'(head_cmd.batch_index)};
	assign a_raddr = {r_q, k_q, m_q};
	assign b_raddr = {k_q, c_q, m_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (head_valid && head_cmd.kind == CMD_READ) begin
					state_d = (n_cfg == '0) ? ST_RESULT : ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				if (k_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (v_s2 && last_s2) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Writes and rejects are done as they are popped but need the result slot free; reads pop at once.
	always_comb begin
		q_pop        = 1'b0;
		a_we         = 1'b0;
		b_we         = 1'b0;
		rd_en        = 1'b0;
		out_load     = 1'b0;
		out_from_acc = 1'b0;
		out_reject   = 1'b0;
		start_read   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					if (head_cmd.kind == CMD_READ) begin
						q_pop      = 1'b1;
						start_read = 1'b1;
					end else if (out_free) begin
						q_pop    = 1'b1;
						out_load = 1'b1;
						case (head_cmd.kind)
							CMD_WRITE_A: a_we       = 1'b1;
							CMD_WRITE_B: b_we       = 1'b1;
							default:     out_reject = 1'b1;
						endcase
					end
				end
			end
			ST_ISSUE: rd_en = 1'b1;
			ST_RESULT: begin
				out_load     = out_free;
				out_from_acc = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (a_we) begin
			a_mem[wr_addr] <= head_cmd.element_value[DATA_WIDTH-1:0];
		end
		if (rd_en) begin
			a_rd_s1 <= a_mem[a_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (b_we) begin
			b_mem[wr_addr] <= head_cmd.element_value[DATA_WIDTH-1:0];
		end
		if (rd_en) begin
			b_rd_s1 <= b_mem[b_raddr];
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= $signed(a_rd_s1) * $signed(b_rd_s1);
		if (start_read) begin
			r_q <= DIM_W'(head_cmd.row_index);
			c_q <= DIM_W'(head_cmd.col_index);
			m_q <= BAT_W'(head_cmd.batch_index);
			n_q <= n_cfg;
		end
	end

	// Floor shift of the exact sum, then clip to the element range.
	always_comb begin
		shifted = acc_q >>> FRAC_BITS;
		if (shifted > SAT_MAX) begin
			sat_val = SAT_MAX[DATA_WIDTH-1:0];
		end else if (shifted < SAT_MIN) begin
			sat_val = SAT_MIN[DATA_WIDTH-1:0];
		end else begin
			sat_val = shifted[DATA_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q   <= out_from_acc ? sat_val : '0;
			out_status_q <= out_reject;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			v_s1        <= 1'b0;
			last_s1     <= 1'b0;
			v_s2        <= 1'b0;
			last_s2     <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start_read) begin
				k_q <= '0;
			end else if (rd_en) begin
				k_q <= k_q + DIM_W'(1);
			end
			v_s1    <= rd_en;
			last_s1 <= rd_en && k_last;
			v_s2    <= v_s1;
			last_s2 <= last_s1;
			if (start_read) begin
				acc_q <= '0;
			end else if (v_s2) begin
				acc_q <= acc_q + ACC_W'(prod_s2);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign product_value = 32'(out_data_q);
	assign status        = out_status_q;

	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> state_q == ST_IDLE)
		else $error("command taken from queue while a read is in progress");

	a_k_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ISSUE |-> NW'(k_q) < n_q)
		else $error("inner index ran past the configured inner size");

	a_last_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && last_s2) |-> state_q == ST_DRAIN)
		else $error("last product arrived outside the drain state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result register loaded over a pending result");

endmodule

// File: dv/tb_batched_matrix_multiply.sv
// Self-checking testbench for the batched matrix multiply block.
module tb_batched_matrix_multiply
	import bmm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT   = 3000;

	localparam logic signed [79:0] SAT_HI = 80'sd2147483647;
	localparam logic signed [79:0] SAT_LO = -80'sd2147483648;

	typedef enum logic [1:0] {
		REG_A_ROWS,
		REG_INNER_SIZE,
		REG_B_COLS,
		REG_BATCH_COUNT
	} reg_index_t;

	typedef struct {
		logic [31:0] product;
		logic        status;
	} response_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // row_index[2:0], col_index[5:3], batch_index[9:6],
	                             // element_value[41:10], zero pad [47:42]
	logic [1:0]  s_tuser = '0;   // action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // product_value
	logic [0:0]  m_tuser;        // status

	// Shadow copy of the matrix stores and the size registers.
	logic [31:0] a_mem [1024];
	logic [31:0] b_mem [1024];
	bit          a_known [1024];
	bit          b_known [1024];
	logic [3:0]  cfg_a_rows = 4'd8;
	logic [3:0]  cfg_inner = 4'd8;
	logic [3:0]  cfg_b_cols = 4'd8;
	logic [4:0]  cfg_batches = 5'd16;

	response_t   pending_responses [$];

	int  errors = 0;
	int  items_sent = 0;
	int  reads_sent = 0;
	int  results_checked = 0;
	int  rejects_seen = 0;
	int  settings_done = 0;
	int  quiet_cycles = 0;

	bit  idle_en = 1'b1;
	bit  hold_req = 1'b0;
	bit  hold_ack = 1'b0;
	int  hold_left = 0;
	int  stall_left = 0;

	batched_matrix_multiply uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #1 clk = ~clk;

	function automatic int eff_rows();
		return (cfg_a_rows > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(cfg_a_rows);
	endfunction

	function automatic int eff_inner();
		return (cfg_inner > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(cfg_inner);
	endfunction

	function automatic int eff_cols();
		return (cfg_b_cols > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(cfg_b_cols);
	endfunction

	function automatic int eff_batches();
		return (cfg_batches > MAX_BATCH_DEF) ? MAX_BATCH_DEF : int'(cfg_batches);
	endfunction

	function automatic int store_addr(int r, int c, int m);
		return (r * MAX_DIM_DEF + c) * MAX_BATCH_DEF + m;
	endfunction

	// Exact dot product over the inner index, floored by the fraction shift, then saturated.
	function automatic logic [31:0] product_element_of(int r, int c, int m);
		logic signed [79:0] acc;
		logic signed [63:0] term;
		logic signed [79:0] shifted;
		int k;
		acc = '0;
		for (k = 0; k < eff_inner(); k++) begin
			term = $signed(a_mem[store_addr(r, k, m)]) * $signed(b_mem[store_addr(k, c, m)]);
			acc = acc + term;
		end
		shifted = acc >>> FRAC_BITS;
		if (shifted > SAT_HI)
			return 32'h7FFF_FFFF;
		if (shifted < SAT_LO)
			return 32'h8000_0000;
		return shifted[31:0];
	endfunction

	task automatic matrix_response(input cmd_kind_t kind, input int r, input int c,
		input int m, input logic [31:0] value);
		response_t resp;
		bit ok;
		resp.product = '0;
		ok = (m < eff_batches());
		case (kind)
			CMD_WRITE_A: begin
				ok = ok && r < eff_rows() && c < eff_inner();
				if (ok) begin
					a_mem[store_addr(r, c, m)] = value;
					a_known[store_addr(r, c, m)] = 1'b1;
				end
			end
			CMD_WRITE_B: begin
				ok = ok && r < eff_inner() && c < eff_cols();
				if (ok) begin
					b_mem[store_addr(r, c, m)] = value;
					b_known[store_addr(r, c, m)] = 1'b1;
				end
			end
			CMD_READ: begin
				ok = ok && r < eff_rows() && c < eff_cols();
				if (ok)
					resp.product = product_element_of(r, c, m);
			end
			default: ok = 1'b0;
		endcase
		resp.status = !ok;
		pending_responses.push_back(resp);
	endtask

	// Offers one item and returns at the edge where it is transferred.
	task automatic send_item(input cmd_kind_t kind, input int r, input int c, input int m,
		input logic [31:0] value);
		if (idle_en && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {6'b0, value, m[3:0], c[2:0], r[2:0]};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		matrix_response(kind, r, c, m, value);
		items_sent++;
		if (kind == CMD_READ)
			reads_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_responses.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input reg_index_t idx, input logic [4:0] value);
		logic [31:0] word;
		word = $urandom();
		word[3:0] = value[3:0];
		if (idx == REG_BATCH_COUNT)
			word[4] = value[4];
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_A_ROWS:      cfg_a_rows = word[3:0];
			REG_INNER_SIZE:  cfg_inner = word[3:0];
			REG_B_COLS:      cfg_b_cols = word[3:0];
			REG_BATCH_COUNT: cfg_batches = word[4:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input int rows, input int inner, input int cols, input int batches);
		drain_results();
		write_register(REG_A_ROWS, rows[4:0]);
		write_register(REG_INNER_SIZE, inner[4:0]);
		write_register(REG_B_COLS, cols[4:0]);
		write_register(REG_BATCH_COUNT, batches[4:0]);
		settings_done++;
	endtask

	function automatic logic [31:0] random_element();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return 32'h7FFF_FFFF;
		if (pick == 1)
			return 32'h8000_0000;
		if (pick == 2)
			return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
		if (pick < 7)
			return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
		return $urandom();
	endfunction

	// Mostly inside the configured size, now and then anywhere in the field.
	function automatic int pick_index(input int limit, input int span);
		if (limit == 0 || $urandom_range(0, 7) == 0)
			return $urandom_range(0, span - 1);
		return $urandom_range(0, (limit > span ? span : limit) - 1);
	endfunction

	// Writes whatever the product still lacks, sometimes overwrites one term, then reads.
	task automatic read_sequence();
		int r;
		int c;
		int m;
		int k;
		r = pick_index(eff_rows(), MAX_DIM_DEF);
		c = pick_index(eff_cols(), MAX_DIM_DEF);
		m = pick_index(eff_batches(), MAX_BATCH_DEF);
		if (r < eff_rows() && c < eff_cols() && m < eff_batches()) begin
			for (k = 0; k < eff_inner(); k++) begin
				if (!a_known[store_addr(r, k, m)])
					send_item(CMD_WRITE_A, r, k, m, random_element());
				if (!b_known[store_addr(k, c, m)])
					send_item(CMD_WRITE_B, k, c, m, random_element());
			end
			if (eff_inner() > 0 && $urandom_range(0, 2) == 0) begin
				k = $urandom_range(0, eff_inner() - 1);
				send_item(CMD_WRITE_A, r, k, m, random_element());
				send_item(CMD_WRITE_B, k, c, m, random_element());
			end
		end
		send_item(CMD_READ, r, c, m, $urandom());
	endtask

	task automatic run_random(input int count);
		int stop_at;
		int pick;
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				read_sequence();
			else if (pick < 7)
				send_item(CMD_WRITE_A, pick_index(eff_rows(), MAX_DIM_DEF),
					pick_index(eff_inner(), MAX_DIM_DEF),
					pick_index(eff_batches(), MAX_BATCH_DEF), random_element());
			else if (pick < 9)
				send_item(CMD_WRITE_B, pick_index(eff_inner(), MAX_DIM_DEF),
					pick_index(eff_cols(), MAX_DIM_DEF),
					pick_index(eff_batches(), MAX_BATCH_DEF), random_element());
			else
				send_item(CMD_REJECT, $urandom_range(0, 7), $urandom_range(0, 7),
					$urandom_range(0, 15), $urandom());
		end
	endtask

	task automatic test_directed_cases();
		apply_setting(8, 1, 8, 16);
		// Largest positive squared saturates high.
		send_item(CMD_WRITE_A, 7, 0, 15, 32'h7FFF_FFFF);
		send_item(CMD_WRITE_B, 0, 7, 15, 32'h7FFF_FFFF);
		send_item(CMD_READ, 7, 7, 15, 32'hFFFF_FFFF);
		send_item(CMD_WRITE_A, 0, 0, 0, 32'h8000_0000);
		send_item(CMD_WRITE_B, 0, 0, 0, 32'h7FFF_FFFF);
		send_item(CMD_READ, 0, 0, 0, 32'h0);
		send_item(CMD_WRITE_B, 0, 0, 0, 32'h8000_0000);
		send_item(CMD_READ, 0, 0, 0, 32'h0);
		send_item(CMD_WRITE_A, 1, 0, 1, 32'h0001_0000);
		send_item(CMD_WRITE_B, 0, 1, 1, 32'hFFFF_0000);
		send_item(CMD_READ, 1, 1, 1, 32'h0);
		// A tiny negative product floors to minus one LSB rather than zero.
		send_item(CMD_WRITE_A, 2, 0, 2, 32'h0000_0001);
		send_item(CMD_WRITE_B, 0, 2, 2, 32'hFFFF_FFFF);
		send_item(CMD_READ, 2, 2, 2, 32'h0);
		send_item(CMD_WRITE_A, 3, 1, 3, 32'h1234_5678);
		send_item(CMD_WRITE_B, 1, 3, 3, 32'h1234_5678);
		send_item(CMD_REJECT, 0, 0, 0, 32'h0);
		apply_setting(8, 2, 8, 2);
		send_item(CMD_READ, 0, 0, 2, 32'h0);
		send_item(CMD_WRITE_A, 0, 0, 2, 32'h0001_0000);
		// Two huge terms that nearly cancel show that the sum is kept exact.
		send_item(CMD_WRITE_A, 4, 0, 1, 32'h7FFF_FFFF);
		send_item(CMD_WRITE_A, 4, 1, 1, 32'h7FFF_FFFF);
		send_item(CMD_WRITE_B, 0, 4, 1, 32'h7FFF_FFFF);
		send_item(CMD_WRITE_B, 1, 4, 1, 32'h8000_0000);
		send_item(CMD_READ, 4, 4, 1, 32'h0);
	endtask

	task automatic test_size_settings();
		int n;
		apply_setting(8, 8, 8, 16);
		run_random(100);
		apply_setting(1, 1, 1, 1);
		run_random(40);
		apply_setting(0, 0, 0, 0);
		run_random(30);
		apply_setting(3, 0, 5, 4);
		run_random(40);
		// Values above the limits act as the limits.
		apply_setting(15, 15, 15, 31);
		run_random(80);
		for (n = 0; n < 3; n++) begin
			apply_setting($urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8),
				$urandom_range(1, 16));
			run_random(60);
		end
		apply_setting($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15),
			$urandom_range(0, 31));
		run_random(30);
	endtask

	task automatic test_output_backpressure();
		apply_setting(8, 4, 8, 16);
		hold_req <= ~hold_req;
		run_random(40);
	endtask

	task automatic test_input_pause();
		run_random(40);
		drain_results();
		run_random(40);
	endtask

	task automatic test_full_rate();
		apply_setting(6, 8, 7, 12);
		idle_en <= 1'b0;
		@(posedge clk);
		run_random(80);
	endtask

	// Result sink: random stall bursts while idles are enabled, plus one long hold on request.
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= LONG_HOLD_CYCLES;
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!idle_en) begin
			m_tready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 15);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		response_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_responses.size() == 0) begin
				$display("%0t: result with none expected: product %h status %0d",
					$time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = pending_responses.pop_front();
				results_checked++;
				if (m_tuser[0])
					rejects_seen++;
				if (m_tdata !== want.product) begin
					$display("%0t: product mismatch: expected %h actual %h",
						$time, want.product, m_tdata);
					errors++;
				end
				if (m_tuser[0] !== want.status) begin
					$display("%0t: status mismatch: expected %0d actual %0d",
						$time, want.status, m_tuser[0]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_size_settings();
		test_output_backpressure();
		test_input_pause();
		test_full_rate();
		drain_results();
		$display("Covered %0d items (%0d product reads) over %0d size settings.",
			items_sent, reads_sent, settings_done);
		$display("Checked %0d results, %0d of them rejections, with %0d mismatches.",
			results_checked, rejects_seen, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
